### sv/psca_pkg.sv
`default_nettype none

package psca_pkg;

  // Default sizes
  localparam int NUM_BUFS_DEF = 1024;
  localparam int N_SILOS_DEF  = 8;

  // Fixed field widths
  localparam int SILO_W  = 3;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 11;

  localparam logic [CFG_W-1:0] MAX_PER_SILO_RESET = 11'd16;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               silo_valid;
    logic [SILO_W-1:0]  silo;
    logic [INDEX_W-1:0] buffer_index;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [INDEX_W-1:0] granted_index;
    logic               via_silo;
    logic [COUNT_W-1:0] shared_free;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

### sv/psca_link_mem.sv
`default_nettype none

// Link RAM: one write port, one read port with registered data.
// After reset a sweep writes entry i <= i+1, one entry per cycle.
module psca_link_mem #(
  parameter int NUM_BUFS = psca_pkg::NUM_BUFS_DEF,
  parameter int AW       = $clog2(NUM_BUFS),
  parameter int LW       = $clog2(NUM_BUFS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [LW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [LW-1:0] wr_data,
  output logic               init_done
);
  import psca_pkg::*;

  logic [LW-1:0] mem [NUM_BUFS];
  logic [LW-1:0] rd_data_r;
  logic [AW-1:0] init_cnt_r;
  logic          init_busy_r;

  logic          we;
  logic [AW-1:0] wa;
  logic [LW-1:0] wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_busy_r <= 1'b1;
      init_cnt_r  <= '0;
    end else if (init_busy_r) begin
      init_cnt_r <= init_cnt_r + 1'b1;
      if (init_cnt_r == AW'(NUM_BUFS - 1)) begin
        init_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    we = init_busy_r | wr_en;
    wa = init_busy_r ? init_cnt_r : wr_addr;
    wd = init_busy_r ? (LW'(init_cnt_r) + LW'(1)) : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign init_done = ~init_busy_r;

endmodule

`default_nettype wire

### sv/psca_silo_file.sv
`default_nettype none

// Per-silo list head and held count, one read and one write port.
module psca_silo_file #(
  parameter int N_SILOS = psca_pkg::N_SILOS_DEF,
  parameter int SW      = 1,
  parameter int LW      = 11,
  parameter int CW      = psca_pkg::CFG_W,
  parameter int EMPTY   = psca_pkg::NUM_BUFS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [SW-1:0] rd_sel,
  output logic      [LW-1:0] rd_head,
  output logic      [CW-1:0] rd_held,
  input  wire logic          wr_en,
  input  wire logic [SW-1:0] wr_sel,
  input  wire logic [LW-1:0] wr_head,
  input  wire logic [CW-1:0] wr_held
);
  import psca_pkg::*;

  logic [LW-1:0] head_r [N_SILOS];
  logic [CW-1:0] held_r [N_SILOS];

  logic rd_in_range;
  logic wr_in_range;

  assign rd_in_range = ({1'b0, rd_sel} < (SW+1)'(N_SILOS));
  assign wr_in_range = ({1'b0, wr_sel} < (SW+1)'(N_SILOS));

  always_comb begin
    rd_head = LW'(EMPTY);
    rd_held = '0;
    if (rd_in_range) begin
      rd_head = head_r[rd_sel];
      rd_held = held_r[rd_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_SILOS; i++) begin
        head_r[i] <= LW'(EMPTY);
        held_r[i] <= '0;
      end
    end else if (wr_en && wr_in_range) begin
      head_r[wr_sel] <= wr_head;
      held_r[wr_sel] <= wr_held;
    end
  end

endmodule

`default_nettype wire

### sv/per_silo_cached_buffer_allocator_core.sv
// Buffer allocator over indices 0..NUM_BUFS-1 with per-silo LIFO caches.
// Input channel (in_valid / in_stall / in_data): one beat is one request,
// allocate or free. Result channel (out_valid / out_stall / out_data): one
// beat per request, in order. A beat moves when valid is high and stall low.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes max_per_silo;
// write it only while no request is in flight.
// Timing: a request is taken in ST_IDLE (the link RAM read is issued); in
// ST_EXEC, once the output register is free, the RAM data is used, the
// lists are updated and the result is loaded into the output register. A
// new request is not taken until the last one has been loaded, since the
// registered link RAM read must return before the lists are updated.
// Reset: the link RAM is swept to its chained reset contents, one entry per
// cycle, so in_stall stays high until the sweep is done. Silo
// heads, counts and the shared list head are cleared at once.
// A stalled result holds in the output register; a request already taken
// waits with it and in_stall stays high until that beat leaves.
`default_nettype none

module per_silo_cached_buffer_allocator_core #(
  parameter int NUM_BUFS = psca_pkg::NUM_BUFS_DEF,
  parameter int N_SILOS  = psca_pkg::N_SILOS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // request channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire psca_pkg::in_item_t        in_data,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output psca_pkg::out_item_t            out_data,
  // config channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [psca_pkg::CFG_W-1:0] cfg_data
);
  import psca_pkg::*;

  localparam int AW = $clog2(NUM_BUFS);           // buffer index
  localparam int LW = $clog2(NUM_BUFS + 1);       // index or empty marker
  localparam int SW = (N_SILOS > 1) ? $clog2(N_SILOS) : 1;
  localparam logic [LW-1:0] EMPTY = LW'(NUM_BUFS);

  // FSM
  state_t state_r, state_nxt;

  // config
  logic [CFG_W-1:0] max_per_silo_r;

  // shared list
  logic [LW-1:0] shared_head_r, shared_head_nxt;
  logic [LW-1:0] shared_cnt_r,  shared_cnt_nxt;

  // request in flight
  logic          ex_free_r;
  logic          ex_ok_r;
  logic          ex_via_r;
  logic [AW-1:0] ex_addr_r;
  logic [SW-1:0] ex_sidx_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  // link RAM
  logic          link_rd_en;
  logic [AW-1:0] link_rd_addr;
  logic [LW-1:0] link_rd_data;
  logic          link_wr_en;
  logic [LW-1:0] link_wr_data;
  logic          init_done;

  // silo file
  logic [SW-1:0] silo_rd_sel;
  logic [LW-1:0] silo_head;
  logic [CFG_W-1:0] silo_held;
  logic          silo_wr_en;
  logic [LW-1:0] silo_wr_head;
  logic [CFG_W-1:0] silo_wr_held;

  // accept-side decode
  logic          in_acc;
  logic          commit;
  logic          out_free;
  logic          is_free;
  logic          has_silo;
  logic [SW-1:0] in_sidx;
  logic          silo_has_buf;
  logic          shared_has_buf;
  logic          idx_ok;
  logic          req_ok;
  logic          req_via;
  logic [AW-1:0] req_addr;

  psca_link_mem #(
    .NUM_BUFS  (NUM_BUFS),
    .AW        (AW),
    .LW        (LW)
  ) u_link_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (link_rd_en),
    .rd_addr   (link_rd_addr),
    .rd_data   (link_rd_data),
    .wr_en     (link_wr_en),
    .wr_addr   (ex_addr_r),
    .wr_data   (link_wr_data),
    .init_done (init_done)
  );

  psca_silo_file #(
    .N_SILOS (N_SILOS),
    .SW      (SW),
    .LW      (LW),
    .CW      (CFG_W),
    .EMPTY   (NUM_BUFS)
  ) u_silo_file (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_sel  (silo_rd_sel),
    .rd_head (silo_head),
    .rd_held (silo_held),
    .wr_en   (silo_wr_en),
    .wr_sel  (ex_sidx_r),
    .wr_head (silo_wr_head),
    .wr_held (silo_wr_held)
  );

  // ---------------------------------------------------------------
  // FSM: next state
  // ---------------------------------------------------------------
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (init_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // FSM: outputs
  always_comb begin
    in_stall    = 1'b1;
    commit      = 1'b0;
    silo_rd_sel = ex_sidx_r;
    unique case (state_r)
      ST_INIT: begin
        in_stall = 1'b1;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        silo_rd_sel = in_sidx;
      end
      ST_EXEC: begin
        commit = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_acc = in_valid & ~in_stall;

  // ---------------------------------------------------------------
  // Accept cycle: pick the path and issue the link read for allocates.
  // A silo number beyond the silo count is handled as no silo.
  // ---------------------------------------------------------------
  always_comb begin
    is_free        = (in_data.kind == KIND_FREE);
    has_silo       = in_data.silo_valid && (32'(in_data.silo) < N_SILOS);
    in_sidx        = SW'(in_data.silo);
    silo_has_buf   = has_silo && (silo_head < EMPTY);
    shared_has_buf = (shared_head_r < EMPTY);
    idx_ok         = (32'(in_data.buffer_index) < NUM_BUFS);

    if (is_free) begin
      req_ok   = idx_ok;
      req_via  = idx_ok && has_silo && (silo_held < max_per_silo_r);
      req_addr = AW'(in_data.buffer_index);
    end else begin
      req_ok   = silo_has_buf | shared_has_buf;
      req_via  = silo_has_buf;
      req_addr = silo_has_buf ? AW'(silo_head) : AW'(shared_head_r);
    end

    link_rd_en   = in_acc && !is_free && req_ok;
    link_rd_addr = req_addr;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_free_r <= is_free;
      ex_ok_r   <= req_ok;
      ex_via_r  <= req_via;
      ex_addr_r <= req_addr;
      ex_sidx_r <= in_sidx;
    end
  end

  // ---------------------------------------------------------------
  // Commit cycle: link data is back; update heads, counts and RAM.
  // ---------------------------------------------------------------
  always_comb begin
    shared_head_nxt = shared_head_r;
    shared_cnt_nxt  = shared_cnt_r;
    silo_wr_en      = commit && ex_ok_r && ex_via_r;
    silo_wr_head    = silo_head;
    silo_wr_held    = silo_held;
    link_wr_en      = commit && ex_ok_r && ex_free_r;
    link_wr_data    = ex_via_r ? silo_head : shared_head_r;

    if (ex_free_r) begin
      // push the freed buffer onto its list
      silo_wr_head = LW'(ex_addr_r);
      silo_wr_held = silo_held + 1'b1;
      if (commit && ex_ok_r && !ex_via_r) begin
        shared_head_nxt = LW'(ex_addr_r);
        if (shared_cnt_r < EMPTY) shared_cnt_nxt = shared_cnt_r + 1'b1;
      end
    end else begin
      // pop: new head is the link of the granted buffer
      silo_wr_head = link_rd_data;
      silo_wr_held = (silo_held != '0) ? (silo_held - 1'b1) : '0;
      if (commit && ex_ok_r && !ex_via_r) begin
        shared_head_nxt = link_rd_data;
        if (shared_cnt_r != '0) shared_cnt_nxt = shared_cnt_r - 1'b1;
      end
    end

    out_data_nxt.ok            = ex_ok_r;
    out_data_nxt.granted_index = (ex_ok_r && !ex_free_r) ? INDEX_W'(ex_addr_r) : '0;
    out_data_nxt.via_silo      = ex_via_r;
    out_data_nxt.shared_free   = COUNT_W'(shared_cnt_nxt);
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_INIT;
      max_per_silo_r <= MAX_PER_SILO_RESET;
      shared_head_r  <= '0;
      shared_cnt_r   <= LW'(NUM_BUFS);
      out_valid_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      shared_head_r <= shared_head_nxt;
      shared_cnt_r  <= shared_cnt_nxt;
      if (cfg_valid) begin
        max_per_silo_r <= cfg_data;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import psca_pkg::*;

  localparam int NBUF  = NUM_BUFS_DEF;
  localparam int NSILO = N_SILOS_DEF;

  // Mirror of the allocator lists; holds the results still owed by the block.
  class alloc_scoreboard;
    logic [COUNT_W-1:0] link_mem   [NBUF];
    logic [COUNT_W-1:0] silo_top   [NSILO];
    logic [COUNT_W-1:0] silo_count [NSILO];
    logic [COUNT_W-1:0] pool_top;
    logic [COUNT_W-1:0] pool_count;
    logic [CFG_W-1:0]   silo_cap;
    out_item_t          due_results[$];
    int                 errors;

    function new();
      for (int i = 0; i < NBUF; i++) link_mem[i] = COUNT_W'(i + 1);
      for (int i = 0; i < NSILO; i++) begin
        silo_top[i]   = COUNT_W'(NBUF);
        silo_count[i] = '0;
      end
      pool_top   = '0;
      pool_count = COUNT_W'(NBUF);
      silo_cap   = MAX_PER_SILO_RESET;
      errors     = 0;
    endfunction

    function void set_silo_cap(logic [CFG_W-1:0] v);
      silo_cap = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Apply one accepted request to the mirror and queue its result.
    function out_item_t book_request(in_item_t rq);
      out_item_t          r;
      logic [COUNT_W-1:0] g;
      int                 s;
      bit                 own;
      r   = '0;
      s   = rq.silo;
      own = rq.silo_valid && (s < NSILO);
      if (rq.kind == KIND_ALLOC) begin
        if (own && silo_top[s] < NBUF) begin
          g               = silo_top[s];
          silo_top[s]     = link_mem[g];
          if (silo_count[s] != 0) silo_count[s]--;
          r.ok            = 1'b1;
          r.via_silo      = 1'b1;
          r.granted_index = g[INDEX_W-1:0];
        end else if (pool_top < NBUF) begin
          g               = pool_top;
          pool_top        = link_mem[g];
          if (pool_count != 0) pool_count--;
          r.ok            = 1'b1;
          r.granted_index = g[INDEX_W-1:0];
        end
      end else if (rq.buffer_index < NBUF) begin
        r.ok = 1'b1;
        if (own && silo_count[s] < silo_cap) begin
          link_mem[rq.buffer_index] = silo_top[s];
          silo_top[s]               = COUNT_W'(rq.buffer_index);
          silo_count[s]++;
          r.via_silo                = 1'b1;
        end else begin
          link_mem[rq.buffer_index] = pool_top;
          pool_top                  = COUNT_W'(rq.buffer_index);
          if (pool_count != NBUF) pool_count++;
        end
      end
      r.shared_free = pool_count;
      due_results.push_back(r);
      return r;
    endfunction

    function void field_cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result beat %h with no result owed", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      field_cmp("ok", 32'(want.ok), 32'(got.ok));
      field_cmp("granted_index", 32'(want.granted_index), 32'(got.granted_index));
      field_cmp("via_silo", 32'(want.via_silo), 32'(got.via_silo));
      field_cmp("shared_free", 32'(want.shared_free), 32'(got.shared_free));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  alloc_scoreboard sb;

  // Idling knobs, in percent of cycles; hold_on forces a long receiver stall.
  int idle_pct;
  int stall_pct;
  bit hold_on;

  // Buffers the requesters currently own, so most frees are legal.
  logic [INDEX_W-1:0] owned_q[$];
  bit                 owned_map[NBUF];
  int                 alloc_fails;

  per_silo_cached_buffer_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall decided at the falling edge, beats checked at the rising edge.
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Long receiver hold-off, counted here while the sender keeps pushing.
  task automatic hold_off(input int cycles);
    hold_on = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on = 1'b0;
  endtask

  // Offer one request beat and wait until the block takes it.
  task automatic issue(input logic k, input logic sv, input logic [SILO_W-1:0] s,
                       input logic [INDEX_W-1:0] idx, output out_item_t want);
    in_item_t rq;
    rq.kind         = k;
    rq.silo_valid   = sv;
    rq.silo         = s;
    rq.buffer_index = idx;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = sb.book_request(rq);
    @(negedge clk);
  endtask

  // Sender goes quiet until every owed result is back, then lets the pipeline settle.
  task automatic wait_all_returned();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_silo_cap(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_silo_cap(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random request. Frees mostly return an owned buffer; wild_pct of
  // them pick any index, which allows double frees.
  task automatic random_request(input int alloc_pct, input int wild_pct);
    logic               k;
    logic [INDEX_W-1:0] idx;
    out_item_t          want;
    int                 pick;
    idx = INDEX_W'($urandom_range(NBUF - 1));
    if (owned_q.size() == 0 || $urandom_range(99) < alloc_pct) begin
      k = KIND_ALLOC;
    end else begin
      k = KIND_FREE;
      if ($urandom_range(99) >= wild_pct) begin
        pick           = $urandom_range(owned_q.size() - 1);
        idx            = owned_q[pick];
        owned_q[pick]  = owned_q[owned_q.size() - 1];
        void'(owned_q.pop_back());
        owned_map[idx] = 1'b0;
      end
    end
    issue(k, $urandom_range(99) < 75, SILO_W'($urandom_range(NSILO - 1)), idx, want);
    if (k == KIND_ALLOC) begin
      if (!want.ok) begin
        alloc_fails++;
      end else if (!owned_map[want.granted_index]) begin
        owned_map[want.granted_index] = 1'b1;
        owned_q.push_back(want.granted_index);
      end
    end
  endtask

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_item_t e;
    int        n;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_on     = 1'b0;
    alloc_fails = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Link RAM sweep runs after reset; the handshakes absorb it.
    write_silo_cap(MAX_PER_SILO_RESET);

    // Directed: pool fresh out of reset holds 0..1023 in order.
    issue(KIND_ALLOC, 1'b0, 3'd7, 10'd1023, e);  // plain alloc, gets 0
    issue(KIND_FREE,  1'b0, 3'd7, 10'd0,    e);  // back to shared, count full
    // Double free with the shared count already full: count saturates.
    issue(KIND_FREE,  1'b0, 3'd7, 10'd1023, e);
    // Silo 7 empty, so its alloc falls through to the shared head (1023).
    issue(KIND_ALLOC, 1'b1, 3'd7, 10'd0,    e);
    // Park 1023 in silo 0 and take it back: ends the loop the double free
    // made, shared list is now 0..1023 with one fewer counted than linked.
    issue(KIND_FREE,  1'b1, 3'd0, 10'd1023, e);
    issue(KIND_ALLOC, 1'b1, 3'd0, 10'd512,  e);
    // Silo count floor: 0 freed twice into silo 3 forms a self loop, so
    // silo 3 keeps handing out 0 after its count reaches zero.
    issue(KIND_ALLOC, 1'b0, 3'd0, 10'd0,    e);
    issue(KIND_FREE,  1'b1, 3'd3, 10'd0,    e);
    issue(KIND_FREE,  1'b1, 3'd3, 10'd0,    e);
    issue(KIND_ALLOC, 1'b1, 3'd3, 10'd1023, e);
    issue(KIND_ALLOC, 1'b1, 3'd3, 10'd1023, e);
    issue(KIND_ALLOC, 1'b1, 3'd3, 10'd1023, e);
    // Freeing 0 into silo 5 terminates the loop; drain both silos again.
    issue(KIND_FREE,  1'b1, 3'd5, 10'd0,    e);
    issue(KIND_ALLOC, 1'b1, 3'd3, 10'd0,    e);
    issue(KIND_ALLOC, 1'b1, 3'd5, 10'd0,    e);
    // Requesters now own buffer 0 only; 1023 sits at the shared tail.
    owned_map[0] = 1'b1;
    owned_q.push_back(10'd0);

    // Largest cap, no idling, receiver held off long enough to back up
    // the input side while the sender keeps offering.
    wait_all_returned();
    write_silo_cap(11'd1024);
    fork
      hold_off(150);
    join_none
    for (n = 0; n < 120; n++) random_request(50, 0);

    // Cap of zero: every free lands in the shared list.
    wait_all_returned();
    write_silo_cap(11'd0);
    stall_pct = 77;
    for (n = 0; n < 120; n++) random_request(75, 0);

    wait_all_returned();
    write_silo_cap(CFG_W'($urandom_range(1, 1023)));
    stall_pct = 0;
    idle_pct  = 77;
    for (n = 0; n < 120; n++) random_request(85, 0);

    // Allocation-heavy run until the shared list empties and allocs fail;
    // the shared count hits zero one entry early and saturates.
    wait_all_returned();
    write_silo_cap(11'd3);
    idle_pct  = 25;
    stall_pct = 25;
    n         = 0;
    while (alloc_fails < 40 && n < 1000) begin
      random_request(97, 0);
      n++;
    end
    // Hover around empty: mixed grants and failures.
    idle_pct  = 0;
    stall_pct = 0;
    for (n = 0; n < 120; n++) random_request(50, 0);

    // Tight cap and arbitrary frees, double frees included.
    wait_all_returned();
    write_silo_cap(11'd1);
    idle_pct  = 77;
    stall_pct = 77;
    for (n = 0; n < 100; n++) random_request(50, 30);

    wait_all_returned();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### per_silo_cached_buffer_allocator_core.f
sv/psca_pkg.sv
sv/psca_link_mem.sv
sv/psca_silo_file.sv
sv/per_silo_cached_buffer_allocator_core.sv
verif/tb.sv
